/* hdl/tq_pkg.sv */
package tq_pkg;

	typedef enum logic [2:0] {
		OP_ADD    = 3'd0,
		OP_CANCEL = 3'd1,
		OP_TICK   = 3'd2,
		OP_EXIST  = 3'd3,
		OP_CLEAR  = 3'd4,
		OP_BAD    = 3'd5
	} op_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	localparam int CNT_W = 7;

	typedef struct packed {
		op_t         op;
		logic [31:0] target_id;
		logic [63:0] expire_at;
		logic [31:0] period;
		logic [63:0] now_time;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [31:0]      assigned_id;
		logic             fired;
		logic [31:0]      fired_id;
		logic [31:0]      fired_period;
		logic [CNT_W-1:0] fire_count;
		logic             last;
	} res_t;

	function automatic op_t classify(input logic [2:0] code);
		op_t r;
		case (code)
			3'd0: r = OP_ADD;
			3'd1: r = OP_CANCEL;
			3'd2: r = OP_TICK;
			3'd3: r = OP_EXIST;
			3'd4: r = OP_CLEAR;
			default: r = OP_BAD;
		endcase
		return r;
	endfunction

endpackage

/* hdl/tq_front.sv */
module tq_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [2:0]      operation,
	input  logic [31:0]     target_id,
	input  logic [63:0]     expire_at,
	input  logic [31:0]     period,
	input  logic [63:0]     now_time,
	output tq_pkg::cmd_t    cmd,
	output logic            cmd_valid,
	input  logic            cmd_ready
);

	tq_pkg::cmd_t ent_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;
	logic         push, pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = ent_q[rp_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	// decoded beat goes into a two-entry queue
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= '{op: tq_pkg::classify(operation), target_id: target_id,
				expire_at: expire_at, period: period, now_time: now_time};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

/* hdl/tq_engine.sv */
module tq_engine #(
	parameter int TIMER_SLOTS = 32,
	parameter int MAX_FIRES   = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tq_pkg::cmd_t  cmd,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	output tq_pkg::res_t  res,
	output logic          res_valid,
	input  logic          res_ready
);

	localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);
	localparam logic [tq_pkg::CNT_W-1:0] FIRE_CAP = tq_pkg::CNT_W'(MAX_FIRES);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_WAIT, S_DONE, S_FLUSH} state_t;

	state_t               state_q;
	tq_pkg::cmd_t         cmd_q;
	tq_pkg::res_t         res_q;
	logic                 ovalid_q;
	logic [TIMER_SLOTS-1:0] valid_q;
	logic [31:0]          idc_q, key_q, nid;
	logic [IDX_W-1:0]     cnt_q, idx_s1;
	logic                 rd_vld_s1;
	logic [127:0]         mem_q [TIMER_SLOTS];
	logic [127:0]         rd_s1;
	logic                 free_found_q, match_found_q, best_found_q;
	logic [IDX_W-1:0]     free_idx_q, match_idx_q, best_idx_q;
	logic [63:0]          best_exp_q;
	logic [31:0]          best_id_q, best_per_q;
	logic                 pend_q;
	logic [31:0]          pend_id_q, pend_per_q;
	logic [tq_pkg::CNT_W-1:0] pend_cnt_q, kcnt_q;
	logic                 out_free, tick_go;
	logic                 we;
	logic [IDX_W-1:0]     wa;
	logic [127:0]         wd;
	logic [64:0]          sum;
	logic [63:0]          new_exp;
	logic [31:0]          r_id, r_per;
	logic [63:0]          r_exp;
	logic                 r_valid;
	logic                 emit;
	tq_pkg::res_t         nxt_res;

	assign cmd_ready = (state_q == S_IDLE);
	assign res       = res_q;
	assign res_valid = ovalid_q;
	assign out_free  = !ovalid_q || res_ready;
	assign nid       = (idc_q + 32'd1 == 32'd0) ? 32'd1 : idc_q + 32'd1;
	assign {r_id, r_exp, r_per} = rd_s1;
	assign r_valid   = valid_q[idx_s1];
	assign tick_go   = !pend_q || out_free;

	assign sum     = {1'b0, best_exp_q} + {33'd0, best_per_q};
	assign new_exp = sum[64] ? '1 : sum[63:0];

	always_comb begin
		we = 1'b0;
		wa = free_idx_q;
		wd = {key_q, cmd_q.expire_at, cmd_q.period};
		if (state_q == S_DONE) begin
			if (cmd_q.op == tq_pkg::OP_ADD) begin
				we = free_found_q && !match_found_q && out_free;
			end else if (cmd_q.op == tq_pkg::OP_TICK) begin
				// periodic reload at expiry plus period, saturating
				we = best_found_q && tick_go && (best_per_q != 32'd0);
				wa = best_idx_q;
				wd = {best_id_q, new_exp, best_per_q};
			end
		end
	end

	// result beat loaded into the output register
	always_comb begin
		emit         = 1'b0;
		nxt_res      = '0;
		nxt_res.last = 1'b1;
		if (state_q == S_DONE) begin
			case (cmd_q.op)
				tq_pkg::OP_TICK: begin
					if (best_found_q) begin
						if (pend_q && out_free) begin
							emit                 = 1'b1;
							nxt_res.fired        = 1'b1;
							nxt_res.fired_id     = pend_id_q;
							nxt_res.fired_period = pend_per_q;
							nxt_res.fire_count   = pend_cnt_q;
							nxt_res.last         = 1'b0;
						end
					end else if (out_free) begin
						emit = 1'b1;
						if (pend_q) begin
							nxt_res.fired        = 1'b1;
							nxt_res.fired_id     = pend_id_q;
							nxt_res.fired_period = pend_per_q;
							nxt_res.fire_count   = pend_cnt_q;
						end
					end
				end
				tq_pkg::OP_ADD: begin
					if (out_free) begin
						emit = 1'b1;
						if (!free_found_q) begin
							nxt_res.status = tq_pkg::ST_FULL;
						end else if (match_found_q) begin
							nxt_res.status = tq_pkg::ST_NOTFOUND;
						end else begin
							nxt_res.status      = tq_pkg::ST_OK;
							nxt_res.assigned_id = key_q;
						end
					end
				end
				default: begin
					if (out_free) begin
						emit = 1'b1;
						if (cmd_q.op == tq_pkg::OP_CLEAR)
							nxt_res.status = tq_pkg::ST_OK;
						else if (cmd_q.op == tq_pkg::OP_BAD)
							nxt_res.status = tq_pkg::ST_NOTFOUND;
						else
							nxt_res.status = match_found_q ? tq_pkg::ST_OK
								: tq_pkg::ST_NOTFOUND;
					end
				end
			endcase
		end else if (state_q == S_FLUSH && out_free) begin
			emit                 = 1'b1;
			nxt_res.fired        = 1'b1;
			nxt_res.fired_id     = pend_id_q;
			nxt_res.fired_period = pend_per_q;
			nxt_res.fire_count   = pend_cnt_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem_q[wa] <= wd;
		rd_s1 <= mem_q[cnt_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			ovalid_q      <= 1'b0;
			res_q         <= '0;
			cmd_q         <= '0;
			valid_q       <= '0;
			idc_q         <= '0;
			key_q         <= '0;
			cnt_q         <= '0;
			idx_s1        <= '0;
			rd_vld_s1     <= 1'b0;
			free_found_q  <= 1'b0;
			match_found_q <= 1'b0;
			best_found_q  <= 1'b0;
			free_idx_q    <= '0;
			match_idx_q   <= '0;
			best_idx_q    <= '0;
			best_exp_q    <= '0;
			best_id_q     <= '0;
			best_per_q    <= '0;
			pend_q        <= 1'b0;
			pend_id_q     <= '0;
			pend_per_q    <= '0;
			pend_cnt_q    <= '0;
			kcnt_q        <= '0;
		end else begin
			ovalid_q <= emit || (ovalid_q && !res_ready);
			if (emit) res_q <= nxt_res;

			rd_vld_s1 <= (state_q == S_SCAN);
			idx_s1    <= cnt_q;

			// one slot compared per cycle
			if (rd_vld_s1) begin
				if (!r_valid && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= idx_s1;
				end
				if (r_valid && r_id == key_q && !match_found_q) begin
					match_found_q <= 1'b1;
					match_idx_q   <= idx_s1;
				end
				if (r_valid && r_exp <= cmd_q.now_time && (!best_found_q ||
					r_exp < best_exp_q || (r_exp == best_exp_q && r_id < best_id_q))) begin
					best_found_q <= 1'b1;
					best_idx_q   <= idx_s1;
					best_exp_q   <= r_exp;
					best_id_q    <= r_id;
					best_per_q   <= r_per;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q         <= cmd;
						cnt_q         <= '0;
						free_found_q  <= 1'b0;
						match_found_q <= 1'b0;
						best_found_q  <= 1'b0;
						pend_q        <= 1'b0;
						kcnt_q        <= '0;
						key_q         <= (cmd.op == tq_pkg::OP_ADD) ? nid : cmd.target_id;
						if (cmd.op == tq_pkg::OP_CLEAR || cmd.op == tq_pkg::OP_BAD)
							state_q <= S_DONE;
						else
							state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_IDX) state_q <= S_WAIT;
				end
				S_WAIT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					case (cmd_q.op)
						tq_pkg::OP_TICK: begin
							if (best_found_q) begin
								if (tick_go) begin
									if (best_per_q == 32'd0) valid_q[best_idx_q] <= 1'b0;
									pend_q       <= 1'b1;
									pend_id_q    <= best_id_q;
									pend_per_q   <= best_per_q;
									pend_cnt_q   <= kcnt_q + 1'b1;
									kcnt_q       <= kcnt_q + 1'b1;
									best_found_q <= 1'b0;
									cnt_q        <= '0;
									if (kcnt_q + 1'b1 == FIRE_CAP) state_q <= S_FLUSH;
									else state_q <= S_SCAN;
								end
							end else if (out_free) begin
								state_q <= S_IDLE;
							end
						end
						tq_pkg::OP_ADD: begin
							if (out_free) begin
								state_q <= S_IDLE;
								if (free_found_q) begin
									idc_q <= key_q;
									if (!match_found_q) valid_q[free_idx_q] <= 1'b1;
								end
							end
						end
						default: begin
							if (out_free) begin
								state_q <= S_IDLE;
								if (cmd_q.op == tq_pkg::OP_CLEAR)
									valid_q <= '0;
								else if (cmd_q.op == tq_pkg::OP_CANCEL && match_found_q)
									valid_q[match_idx_q] <= 1'b0;
							end
						end
					endcase
				end
				S_FLUSH: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* hdl/timeout_queue_top.sv */
// Timer table with periodic reload. Beats enter a two-entry command queue and
// are carried out by an engine that walks the slot memory one entry per cycle.
// Add, cancel and exist each take one full slot scan; clear and unknown
// operations skip the scan. A tick that fires timers below the cap takes one
// full slot scan per firing to find the earliest expired timer and a final scan
// that finds none; a tick that reaches MAX_FIRES ends with no final scan and
// flushes its last firing. Each result step also waits while the output
// register still holds a beat that has not been taken.
module timeout_queue_top #(
	parameter int TIMER_SLOTS = 32,
	parameter int MAX_FIRES   = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [31:0] target_id,
	input  logic [63:0] expire_at,
	input  logic [31:0] period,
	input  logic [63:0] now_time,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] assigned_id,
	output logic        fired,
	output logic [31:0] fired_id,
	output logic [31:0] fired_period,
	output logic [6:0]  fire_count,
	output logic        last
);

	tq_pkg::cmd_t cmd;
	tq_pkg::res_t res;
	logic         cmd_valid, cmd_ready;

	tq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.target_id (target_id),
		.expire_at (expire_at),
		.period    (period),
		.now_time  (now_time),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready)
	);

	tq_engine #(
		.TIMER_SLOTS (TIMER_SLOTS),
		.MAX_FIRES   (MAX_FIRES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.res       (res),
		.res_valid (out_valid),
		.res_ready (out_ready)
	);

	assign status       = res.status;
	assign assigned_id  = res.assigned_id;
	assign fired        = res.fired;
	assign fired_id     = res.fired_id;
	assign fired_period = res.fired_period;
	assign fire_count   = res.fire_count;
	assign last         = res.last;

	a_fired_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fired |-> status == tq_pkg::ST_OK && fire_count != 7'd0
		&& assigned_id == 32'd0)
		else $error("fired beat with bad status or count");

	a_nofire_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !fired |-> fire_count == 7'd0 && last)
		else $error("non-firing beat not final");

	a_cap_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fired && fire_count == 7'(MAX_FIRES) |-> last)
		else $error("beat at fire cap not final");

endmodule
